// File: sv/lfu_pkg.sv
package lfu_pkg;

    // Default table geometry.
    localparam int ENTRIES_DEF  = 32;
    localparam int KEY_BITS_DEF = 16;

    // Fixed field widths.
    localparam int HIT_BITS   = 16;
    localparam int BYTE_BITS  = 32;
    localparam int TOTAL_BITS = 38;
    localparam int KIND_BITS  = 3;
    localparam int OKEY_BITS  = 16;
    localparam int IKEY_BITS  = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 96;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic [BYTE_BITS-1:0] LIMIT_RESET = 32'd16777216;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_HIT   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_STORE = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_NODEC = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_FULL  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_EVICT = 3'd4;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_START,
        ST_SCAN,
        ST_EVICT
    } st_t;

endpackage

// File: sv/lfu_cell.sv
module lfu_cell
    import lfu_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int IW       = 5,
    parameter int CELL_IDX = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Lookup and update from the sequencer.
    input  logic [KEY_BITS-1:0]  look_key,
    output logic                 match,
    output logic                 valid,
    input  logic                 wr,
    input  logic [BYTE_BITS-1:0] wr_bytes,
    input  logic                 inc,
    input  logic                 clr,
    // Candidate from the left neighbor.
    input  logic                 in_go,
    input  logic                 in_have,
    input  logic [HIT_BITS-1:0]  in_hits,
    input  logic [BYTE_BITS-1:0] in_bytes,
    input  logic [KEY_BITS-1:0]  in_key,
    input  logic [IW-1:0]        in_idx,
    // Candidate to the right neighbor.
    output logic                 out_go,
    output logic                 out_have,
    output logic [HIT_BITS-1:0]  out_hits,
    output logic [BYTE_BITS-1:0] out_bytes,
    output logic [KEY_BITS-1:0]  out_key,
    output logic [IW-1:0]        out_idx
);

    logic                 valid_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [BYTE_BITS-1:0] bytes_reg;
    logic [HIT_BITS-1:0]  hits_reg;
    logic                 go_reg, have_reg;
    logic [HIT_BITS-1:0]  chits_reg;
    logic [BYTE_BITS-1:0] cbytes_reg;
    logic [KEY_BITS-1:0]  ckey_reg;
    logic [IW-1:0]        cidx_reg;
    logic                 own_first;

    assign match = valid_reg && (key_reg == look_key);
    assign valid = valid_reg;

    // The stored entry ranks first on fewer hits, then smaller size, then lower key.
    always_comb begin
        own_first = 1'b0;
        if (valid_reg) begin
            if (!in_have) begin
                own_first = 1'b1;
            end else if (hits_reg != in_hits) begin
                own_first = hits_reg < in_hits;
            end else if (bytes_reg != in_bytes) begin
                own_first = bytes_reg < in_bytes;
            end else begin
                own_first = key_reg < in_key;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr) begin
            valid_reg <= 1'b1;
        end else if (clr) begin
            valid_reg <= 1'b0;
        end
        if (wr) begin
            key_reg   <= look_key;
            bytes_reg <= wr_bytes;
            hits_reg  <= '0;
        end else if (inc && hits_reg != {HIT_BITS{1'b1}}) begin
            hits_reg <= hits_reg + 1'b1;
        end
    end

    // Candidate stage handed on to the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            go_reg <= 1'b0;
        end else begin
            go_reg <= in_go;
        end
        have_reg <= in_have || valid_reg;
        if (own_first) begin
            chits_reg  <= hits_reg;
            cbytes_reg <= bytes_reg;
            ckey_reg   <= key_reg;
            cidx_reg   <= IW'(CELL_IDX);
        end else begin
            chits_reg  <= in_hits;
            cbytes_reg <= in_bytes;
            ckey_reg   <= in_key;
            cidx_reg   <= in_idx;
        end
    end

    assign out_go    = go_reg;
    assign out_have  = have_reg;
    assign out_hits  = chits_reg;
    assign out_bytes = cbytes_reg;
    assign out_key   = ckey_reg;
    assign out_idx   = cidx_reg;

endmodule

// File: sv/lfu_size_cache_eviction.sv
// Channel   | Dir | Transfer contents
// s_axis    | in  | tdata: request key, decoded byte size, decode flag
// m_axis    | out | tdata: kind, evicted_key, evicted_bytes, total_bytes; tlast: last
// apb       | in  | byte_limit at address 0
//
// A hit, an undecoded miss or a full table is answered from the lookup state.
// A stored miss is answered there too and may then start evictions: each
// eviction sends a candidate down the row of cells, one cell per cycle.
// Reset is synchronous and clears all entries at once.
// A stalled result holds the sequencer; a new request is taken once it is idle.
module lfu_size_cache_eviction
    import lfu_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // req_key[15:0], req_bytes[47:16], decode_ok[48], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // kind[2:0], evicted_key[18:3], evicted_bytes[50:19], total_bytes[88:51], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = TOTAL_BITS + 7;

    st_t state_reg, state_next;

    logic [BYTE_BITS-1:0]  limit_reg;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [BYTE_BITS-1:0]  bytes_reg;
    logic                  ok_reg;
    logic [BYTE_BITS-1:0]  bbytes_reg;
    logic [KEY_BITS-1:0]   bkey_reg;
    logic [IW-1:0]         bidx_reg;

    logic                  mvalid_reg;
    logic [KIND_BITS-1:0]  okind_reg, okind_next;
    logic [OKEY_BITS-1:0]  okey_reg, okey_next;
    logic [BYTE_BITS-1:0]  obytes_reg, obytes_next;
    logic                  olast_reg, olast_next;
    logic [TOTAL_BITS-1:0] ototal_reg;
    logic                  emit;

    logic [ENTRIES-1:0] match_v, valid_v, wr_v, inc_v, clr_v;
    logic               hit, found, prune, more, go, out_free;
    logic [IW-1:0]      free_idx;
    logic [TOTAL_BITS-1:0] total_add, total_sub;
    logic [ENTRIES-1:0] best_oh;
    logic [SW-1:0]      lim85;

    // Candidate chain between cells.
    logic                 c_go   [0:ENTRIES];
    logic                 c_have [0:ENTRIES];
    logic [HIT_BITS-1:0]  c_hits [0:ENTRIES];
    logic [BYTE_BITS-1:0] c_bytes[0:ENTRIES];
    logic [KEY_BITS-1:0]  c_key  [0:ENTRIES];
    logic [IW-1:0]        c_idx  [0:ENTRIES];

    assign c_go[0]    = go;
    assign c_have[0]  = 1'b0;
    assign c_hits[0]  = '0;
    assign c_bytes[0] = '0;
    assign c_key[0]   = '0;
    assign c_idx[0]   = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .KEY_BITS (KEY_BITS),
            .IW       (IW),
            .CELL_IDX (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .look_key  (key_reg),
            .match     (match_v[g]),
            .valid     (valid_v[g]),
            .wr        (wr_v[g]),
            .wr_bytes  (bytes_reg),
            .inc       (inc_v[g]),
            .clr       (clr_v[g]),
            .in_go     (c_go[g]),
            .in_have   (c_have[g]),
            .in_hits   (c_hits[g]),
            .in_bytes  (c_bytes[g]),
            .in_key    (c_key[g]),
            .in_idx    (c_idx[g]),
            .out_go    (c_go[g+1]),
            .out_have  (c_have[g+1]),
            .out_hits  (c_hits[g+1]),
            .out_bytes (c_bytes[g+1]),
            .out_key   (c_key[g+1]),
            .out_idx   (c_idx[g+1])
        );
    end

    // The total is above the low-water mark when 100*total > 85*limit.
    function automatic logic over_mark(input logic [TOTAL_BITS-1:0] t,
                                       input logic [SW-1:0] l85);
        logic [SW-1:0] t100;
        begin
            t100 = SW'({t, 6'b0}) + SW'({t, 5'b0}) + SW'({t, 2'b0});
            over_mark = t100 > l85;
        end
    endfunction

    assign lim85 = SW'({limit_reg, 6'b0}) + SW'({limit_reg, 4'b0})
                 + SW'({limit_reg, 2'b0}) + SW'(limit_reg);

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        found    = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!valid_v[i]) begin
                free_idx = IW'(i);
                found    = 1'b1;
            end
        end
    end

    assign hit       = |match_v;
    assign out_free  = !mvalid_reg || m_tready;
    assign total_add = total_reg + TOTAL_BITS'(bytes_reg);
    assign total_sub = total_reg - TOTAL_BITS'(bbytes_reg);
    assign best_oh   = ENTRIES'(1) << bidx_reg;
    assign prune     = (total_add >= TOTAL_BITS'(limit_reg)) && over_mark(total_add, lim85);
    assign more      = over_mark(total_sub, lim85) && (|(valid_v & ~best_oh));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOOK;
            end
            ST_LOOK: begin
                if (out_free) begin
                    if (!hit && ok_reg && found && prune) state_next = ST_START;
                    else state_next = ST_IDLE;
                end
            end
            ST_START: state_next = ST_SCAN;
            ST_SCAN: begin
                if (c_go[ENTRIES]) state_next = ST_EVICT;
            end
            ST_EVICT: begin
                if (out_free) state_next = more ? ST_START : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Strobes to the cells and the result to send.
    always_comb begin
        emit        = 1'b0;
        go          = 1'b0;
        wr_v        = '0;
        inc_v       = '0;
        clr_v       = '0;
        total_next  = total_reg;
        okind_next  = okind_reg;
        okey_next   = '0;
        obytes_next = '0;
        olast_next  = 1'b1;
        case (state_reg)
            ST_LOOK: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (hit) begin
                        okind_next = KIND_HIT;
                        inc_v      = match_v;
                    end else if (!ok_reg) begin
                        okind_next = KIND_NODEC;
                    end else if (!found) begin
                        okind_next = KIND_FULL;
                    end else begin
                        okind_next = KIND_STORE;
                        wr_v       = ENTRIES'(1) << free_idx;
                        total_next = total_add;
                        olast_next = !prune;
                    end
                end
            end
            ST_START: go = 1'b1;
            ST_EVICT: begin
                if (out_free) begin
                    emit        = 1'b1;
                    clr_v       = best_oh;
                    total_next  = total_sub;
                    okind_next  = KIND_EVICT;
                    okey_next   = OKEY_BITS'(bkey_reg);
                    obytes_next = bbytes_reg;
                    olast_next  = !more;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, request, best candidate and total.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
        if (state_reg == ST_IDLE && s_tvalid) begin
            key_reg   <= KEY_BITS'(s_tdata[IKEY_BITS-1:0]);
            bytes_reg <= s_tdata[47:16];
            ok_reg    <= s_tdata[48];
        end
        if (state_reg == ST_SCAN && c_go[ENTRIES]) begin
            bbytes_reg <= c_bytes[ENTRIES];
            bkey_reg   <= c_key[ENTRIES];
            bidx_reg   <= c_idx[ENTRIES];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (emit) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (emit) begin
            okind_reg  <= okind_next;
            okey_reg   <= okey_next;
            obytes_reg <= obytes_next;
            olast_reg  <= olast_next;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            limit_reg <= pwdata;
        end
    end

    // The total field reports the total at the time of emission.
    always_ff @(posedge aclk) begin
        if (emit) ototal_reg <= total_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'b0, ototal_reg, obytes_reg, okey_reg, okind_reg};
    assign prdata   = paddr[2] ? 32'd0 : limit_reg;
    assign pready   = 1'b1;

endmodule

// File: test/tb.sv
module tb;
    import lfu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 32;
    localparam logic [PADDR_W-1:0] ADDR_LIMIT = '0;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [OKEY_BITS-1:0]  ekey;
        logic [BYTE_BITS-1:0]  ebytes;
        logic [TOTAL_BITS-1:0] total;
        logic                  last;
    } cache_result_t;

    // Scoreboard: a shadow copy of the image cache and its pending results.
    class cache_scoreboard;
        bit                   valid[NSLOT];
        logic [15:0]          key[NSLOT];
        logic [31:0]          size[NSLOT];
        logic [15:0]          hits[NSLOT];
        logic [37:0]          total;
        logic [31:0]          limit;
        cache_result_t        pending[$];
        int                   errors;

        function void clear();
            foreach (valid[i]) valid[i] = 0;
            total = '0;
            limit = LIMIT_RESET;
            errors = 0;
        endfunction

        function void push(logic [2:0] kind, logic [15:0] k, logic [31:0] b, bit last);
            cache_result_t r;
            r.kind = kind; r.ekey = k; r.ebytes = b; r.total = total; r.last = last;
            pending.insert(pending.size(), r);
        endfunction

        function bit ranks_first(int a, int b);
            if (hits[a] != hits[b]) return hits[a] < hits[b];
            if (size[a] != size[b]) return size[a] < size[b];
            return key[a] < key[b];
        endfunction

        // Note one accepted request and queue the results it causes.
        function void note_request(logic [15:0] k, logic [31:0] b, bit ok);
            int slot;
            int best;
            logic [63:0] low_mark;
            slot = -1;
            for (int i = 0; i < NSLOT; i++) begin
                if (valid[i] && key[i] == k) begin
                    if (hits[i] != 16'hFFFF) hits[i]++;
                    push(KIND_HIT, 0, 0, 1);
                    return;
                end
            end
            if (!ok) begin
                push(KIND_NODEC, 0, 0, 1);
                return;
            end
            for (int i = 0; i < NSLOT; i++) begin
                if (!valid[i] && slot < 0) slot = i;
            end
            if (slot < 0) begin
                push(KIND_FULL, 0, 0, 1);
                return;
            end
            valid[slot] = 1; key[slot] = k; size[slot] = b; hits[slot] = 0;
            total = total + b;
            push(KIND_STORE, 0, 0, 0);
            if (total >= limit) begin
                low_mark = (64'(limit) * 85) / 100;
                while (64'(total) > low_mark) begin
                    best = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (valid[i] && (best < 0 || ranks_first(i, best))) best = i;
                    if (best < 0) break;
                    valid[best] = 0;
                    total = total - size[best];
                    push(KIND_EVICT, key[best], size[best], 0);
                end
            end
            pending[$].last = 1;
        endfunction

        // Compare one result transfer with the oldest expectation.
        function void check_result(cache_result_t got);
            cache_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (got !== want) begin
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    cache_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;

    lfu_size_cache_eviction DUT (.*);

    always #10 aclk = ~aclk;

    // Result side: random stalls, plus a long hold-off when asked.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{m_tdata[2:0], m_tdata[18:3], m_tdata[50:19],
                              m_tdata[88:51], m_tlast});
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_limit(logic [31:0] value);
        psel <= 1; pwrite <= 1; paddr <= ADDR_LIMIT; pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.limit = value;
    endtask

    // Wait until every expected result has come, then let the block settle.
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (NSLOT + 8) @(posedge aclk);
    endtask

    // The valid line stays high after a transfer until an idle cycle or a drain.
    task automatic send_request(logic [15:0] k, logic [31:0] b, bit ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {7'd0, ok, b, k};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(k, b, ok);
    endtask

    // Random request biased to a small key pool so hits and evictions happen.
    task automatic random_request();
        logic [15:0] k;
        logic [31:0] b;
        case ($urandom_range(3))
            0: k = 16'($urandom());
            default: k = 16'($urandom_range(40));
        endcase
        case ($urandom_range(4))
            0: b = $urandom();
            1: b = $urandom_range(16);
            default: b = $urandom_range(4000);
        endcase
        send_request(k, b, $urandom_range(9) != 0);
    endtask

    initial begin
        sb.clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: hits, undecoded miss, extremes, limit zero, full table.
        send_request(16'd5, 32'd100, 1);
        send_request(16'd5, 32'd0, 0);
        send_request(16'd6, 32'd7, 0);
        send_request(16'hFFFF, 32'hFFFF_FFFF, 1);
        send_request(16'd0, 32'd0, 1);
        drain();
        write_limit(32'd0);
        send_request(16'd9, 32'd50, 1);
        send_request(16'd10, 32'd0, 1);
        drain();
        write_limit(32'hFFFF_FFFF);
        for (int i = 0; i < 34; i++) send_request(16'(i + 100), 32'(i), 1);
        send_request(16'd100, 32'd0, 0);
        drain();

        // Random phases with several limits and idling patterns.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            write_limit(ph == 3 ? 32'd1 : 32'($urandom_range(4000, 40000)));
            if (ph == 2) begin
                hold_off = 1;
                fork
                    begin repeat (400) @(posedge aclk); hold_off = 0; end
                    repeat (20) random_request();
                join
            end
            for (int n = 0; n < 100; n++) random_request();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("tb: errors");
        $finish;
    end
endmodule
